>>> hw/rtl/three_wire_rtc_serial_master_macros.svh
// ----------------------------------------------------------------------------
// Three-wire RTC serial master: assertion macros
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_MACROS_SVH

`ifndef SYNTHESIS
// Check a whole property on every clock edge outside reset.
`define TWRTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("twrtc check failed");
// Check that a condition implies a consequence in the same cycle.
`define TWRTC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twrtc check failed");
`else
`define TWRTC_ASSERT(label, prop)
`define TWRTC_ASSERT_IMPL(label, ante, cons)
`endif

`endif

>>> hw/rtl/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// Three-wire RTC serial master: shared package
// Beat layouts, phase codes and fixed constants of the serial engine.
// ----------------------------------------------------------------------------
`default_nettype none

package twrtc_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_HOLD  = 1'd1;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd36;
  localparam logic [7:0] SETUP_HOLD_RST  = 8'd8;
  localparam logic [7:0] CMD_READ_FLAG   = 8'h80;
  localparam logic [2:0] LAST_BIT        = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETUP1 = 3'd1,
    PH_SETUP2 = 3'd2,
    PH_LOW    = 3'd3,
    PH_HIGH   = 3'd4,
    PH_HOLD1  = 3'd5,
    PH_HOLD2  = 3'd6
  } phase_t;

  // Input beat, last field in the lowest bits
  typedef struct packed {
    logic [5:0] pad;
    logic       sio_in;
    logic [7:0] tx_byte;
    logic [7:0] byte_count;
    logic [6:0] reg_addr;
    logic       is_read;
    logic       start_req;
  } in_item_t;

  // Result beat, last field in the lowest bits
  typedef struct packed {
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_taken;
    logic       busy_res;
    logic       sio_drive;
    logic       sio_out;
    logic       sck_pin;
    logic       cs_pin;
  } out_item_t;

  // Queue head as seen by the engine
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

>>> hw/rtl/twrtc_queue.sv
// ----------------------------------------------------------------------------
// Three-wire RTC serial master: front queue
// Accept tick beats and hold up to two of them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_wire_rtc_serial_master_macros.svh"

module twrtc_queue (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [twrtc_pkg::IN_TDATA_W-1:0]    s_tdata,
  output twrtc_pkg::q_head_t                  head,
  input  wire                                 pop
);
  import twrtc_pkg::*;

  in_item_t   store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  in_item_t   in_item;

  always_comb begin
    in_item     = in_item_t'(s_tdata);
    in_item.pad = '0;
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign head.valid = (count != 2'd0);
  assign head.item  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `TWRTC_ASSERT(a_count_range, count != 2'd3)
  `TWRTC_ASSERT_IMPL(a_pop_nonempty, pop, count != 2'd0)
  `TWRTC_ASSERT(a_count_up, (push && !pop) |=> (count == $past(count) + 2'd1))

endmodule

`default_nettype wire

>>> hw/rtl/twrtc_engine.sv
// ----------------------------------------------------------------------------
// Three-wire RTC serial master: pin engine
// Step the transfer phases once per tick and register the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_wire_rtc_serial_master_macros.svh"

module twrtc_engine (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [twrtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [twrtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire  twrtc_pkg::q_head_t            head,
  output logic                                pop,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [twrtc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import twrtc_pkg::*;

  logic [7:0] half_period;
  logic [7:0] setup_hold;
  logic [7:0] hp_eff;
  logic [7:0] sh_eff;

  phase_t     phase, phase_next;
  logic [7:0] wait_count, wait_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic       read_mode, read_mode_next;
  logic       cs, cs_next;
  logic       sck, sck_next;
  logic       sio, sio_next;
  logic       drv, drv_next;

  logic       taken, rxv, done, begin_bit;
  logic [7:0] rxb;
  in_item_t   it;
  out_item_t  res;

  assign it     = head.item;
  assign hp_eff = (half_period == 8'd0) ? 8'd1 : half_period;
  assign sh_eff = (setup_hold == 8'd0) ? 8'd1 : setup_hold;
  assign pop    = head.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      setup_hold  <= SETUP_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period <= cfg_data;
        REG_SETUP_HOLD:  setup_hold  <= cfg_data;
        default:         half_period <= half_period;
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_index_next  = bit_index;
    bytes_left_next = bytes_left;
    shift_reg_next  = shift_reg;
    read_mode_next  = read_mode;
    cs_next         = cs;
    sck_next        = sck;
    sio_next        = sio;
    drv_next        = drv;
    taken           = 1'b0;
    rxv             = 1'b0;
    rxb             = 8'd0;
    done            = 1'b0;
    begin_bit       = 1'b0;

    if (phase != PH_IDLE && phase <= PH_HOLD2 && wait_count > 8'd1) begin
      wait_count_next = wait_count - 8'd1;
    end else begin
      unique case (phase)
        PH_SETUP1: begin
          cs_next         = 1'b1;
          phase_next      = PH_SETUP2;
          wait_count_next = sh_eff;
        end
        PH_SETUP2: begin
          bit_index_next = 3'd0;
          begin_bit      = 1'b1;
        end
        PH_LOW: begin
          shift_reg_next  = drv ? {1'b0, shift_reg[7:1]} : {it.sio_in, shift_reg[7:1]};
          sck_next        = 1'b1;
          phase_next      = PH_HIGH;
          wait_count_next = hp_eff;
        end
        PH_HIGH: begin
          if (bit_index != LAST_BIT) begin
            bit_index_next = bit_index + 3'd1;
            begin_bit      = 1'b1;
          end else begin
            bit_index_next = 3'd0;
            if (!drv) begin
              rxv = 1'b1;
              rxb = shift_reg;
            end
            if (bytes_left == 8'd0) begin
              phase_next      = PH_HOLD1;
              wait_count_next = sh_eff;
            end else begin
              bytes_left_next = bytes_left - 8'd1;
              if (read_mode) begin
                drv_next       = 1'b0;
                shift_reg_next = 8'd0;
              end else begin
                drv_next       = 1'b1;
                shift_reg_next = it.tx_byte;
                taken          = 1'b1;
              end
              begin_bit = 1'b1;
            end
          end
        end
        PH_HOLD1: begin
          cs_next         = 1'b0;
          phase_next      = PH_HOLD2;
          wait_count_next = sh_eff;
        end
        PH_HOLD2: begin
          phase_next      = PH_IDLE;
          wait_count_next = 8'd0;
          cs_next         = 1'b0;
          sck_next        = 1'b1;
          sio_next        = 1'b0;
          drv_next        = 1'b1;
          done            = 1'b1;
        end
        default: begin
          // idle, and the unused phase code
          phase_next      = PH_IDLE;
          wait_count_next = 8'd0;
          if (it.start_req) begin
            read_mode_next  = it.is_read;
            shift_reg_next  = {1'b0, it.reg_addr} | (it.is_read ? CMD_READ_FLAG : 8'd0);
            bytes_left_next = it.byte_count;
            bit_index_next  = 3'd0;
            cs_next         = 1'b0;
            sck_next        = 1'b1;
            sio_next        = 1'b0;
            drv_next        = 1'b1;
            phase_next      = PH_SETUP1;
            wait_count_next = sh_eff;
          end
        end
      endcase
      if (begin_bit) begin
        sck_next        = 1'b0;
        sio_next        = drv_next ? shift_reg_next[0] : 1'b0;
        phase_next      = PH_LOW;
        wait_count_next = hp_eff;
      end
    end
  end

  always_comb begin
    res.cs_pin    = cs_next;
    res.sck_pin   = sck_next;
    res.sio_out   = sio_next;
    res.sio_drive = drv_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.tx_taken  = taken;
    res.rx_valid  = rxv;
    res.rx_byte   = rxb;
    res.done_res  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= 8'd0;
      bit_index  <= 3'd0;
      bytes_left <= 8'd0;
      shift_reg  <= 8'd0;
      read_mode  <= 1'b0;
      cs         <= 1'b0;
      sck        <= 1'b1;
      sio        <= 1'b0;
      drv        <= 1'b1;
    end else if (pop) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_index  <= bit_index_next;
      bytes_left <= bytes_left_next;
      shift_reg  <= shift_reg_next;
      read_mode  <= read_mode_next;
      cs         <= cs_next;
      sck        <= sck_next;
      sio        <= sio_next;
      drv        <= drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= OUT_TDATA_W'(res);
    end
  end

  `TWRTC_ASSERT(a_fire_gives_beat, pop |=> m_tvalid)
  `TWRTC_ASSERT(a_hold_without_tick, !pop |=> $stable(phase) && $stable(wait_count))
  `TWRTC_ASSERT_IMPL(a_idle_pins, phase == PH_IDLE, !cs && sck && drv)

endmodule

`default_nettype wire

>>> hw/rtl/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// Three-wire RTC serial master: top level
// Each beat on the s_ channel is one tick of the pin timing base; every tick
// gives exactly one result beat on the m_ channel carrying the pin levels
// after that tick, busy and done status, the tx_taken strobe and any byte
// received. A tick with start_req set while idle opens a transfer: command
// byte (register number, bit 7 set for a read), then byte_count data bytes,
// each sent or received least significant bit first, framed by the set-up
// and hold waits around both chip select edges.
// Throughput: one tick a cycle while m_tready keeps the result register
// free. A tick is first written into the two-entry input queue; its result
// is registered on the edge that pops it from that queue.
// When m_tready is low the result register holds; the queue keeps taking
// ticks until both entries are full, then s_tready drops.
// Reset (rst, synchronous): queue empty, no result pending, engine idle with
// chip select low, clock high, data driven low; half period back to 36 ticks,
// set-up/hold back to 8 ticks. Write the registers only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wire_rtc_serial_master (
  input  wire                                 clk,
  input  wire                                 rst,
  // configuration: index 0 half period, index 1 set-up/hold ticks
  input  wire                                 cfg_we,
  input  wire  [twrtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [twrtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // tick beats
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // s_tdata from bit 0: start_req, is_read, reg_addr[6:0], byte_count[7:0],
  // tx_byte[7:0], sio_in, zero padding
  input  wire  [twrtc_pkg::IN_TDATA_W-1:0]    s_tdata,
  // result beats
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // m_tdata from bit 0: cs_pin, sck_pin, sio_out, sio_drive, busy_res,
  // tx_taken, rx_valid, rx_byte[7:0], done_res
  output logic [twrtc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import twrtc_pkg::*;

  q_head_t head;
  logic    pop;

  // Front: take tick beats and queue them
  twrtc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .pop      (pop)
  );

  // Back: step the phases and register each result beat
  twrtc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
